/* rtl/assert_macros.svh */
// Assertion macros used by the checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define ASSERT_ACTIVE(name, clk_s, rst_s, prop) \
    name: assert property (@(posedge clk_s) disable iff (!rst_s) prop) \
        else $error("assertion failed");

// Checked at every edge, reset included.
`define ASSERT_ALWAYS(name, clk_s, prop) \
    name: assert property (@(posedge clk_s) prop) \
        else $error("assertion failed");

`endif

/* rtl/lpht_pkg.sv */
package lpht_pkg;

    localparam int unsigned SLOTS_DEFAULT = 1024;
    localparam int unsigned KEY_W         = 64;
    localparam int unsigned VAL_W         = 64;
    localparam int unsigned HASH_SHIFT    = 16;
    localparam int unsigned HASH_MUL_W    = 27;
    localparam logic [HASH_MUL_W-1:0] HASH_MUL = 27'h45d9f3b;

    localparam logic REQ_INSERT  = 1'b0;
    localparam logic REQ_LOOKUP  = 1'b1;
    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    typedef struct packed {
        logic             req_type;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value_in;
    } req_t;

    typedef struct packed {
        logic             found;
        logic [VAL_W-1:0] value_out;
        logic             status;
    } rsp_t;

    typedef struct packed {
        logic             used;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
    } slot_entry_t;

endpackage

/* rtl/lpht_ram.sv */
module lpht_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/linear_probe_hash_table_unit.sv */
// Channel   Direction  Handshake                 Payload
// in        in         in_valid / in_ready       in_data  (lpht_pkg::req_t)
// out       out        out_valid / out_ready     out_data (lpht_pkg::rsp_t)
// cfg       in         cfg_wr_en                 cfg_wr_data (miss value)
//
// After a request is taken its key is hashed, the slots are probed from the hashed
// start slot (one per cycle) and the result is put out, after which the next request
// can be taken; a lookup of key zero or into an empty table skips hash and probe.
// The hash runs two multiply rounds, each two passes of one 32x27 multiplier.
// After reset a clearing pass marks every slot free; in_ready stays low meanwhile.
// A result held by out_ready low stalls the next one in its finish state; a new
// request is still taken while a result waits.
module linear_probe_hash_table_unit #(
    parameter int unsigned SLOTS = lpht_pkg::SLOTS_DEFAULT
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  lpht_pkg::req_t        in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output lpht_pkg::rsp_t        out_data,
    input  logic                  cfg_wr_en,
    input  logic [63:0]           cfg_wr_data
);

    import lpht_pkg::*;

    localparam int unsigned IW = $clog2(SLOTS);
    localparam int unsigned CW = IW + 1;
    localparam int unsigned EW = $bits(slot_entry_t);
    localparam int unsigned PW = 32 + HASH_MUL_W;
    localparam logic [IW-1:0]   LAST_SLOT  = IW'(SLOTS - 1);
    localparam logic [CW+1:0]   LOAD_LIMIT = (CW+2)'(3 * SLOTS);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_MUL_LO,
        S_MUL_HI,
        S_SLOT,
        S_PROBE,
        S_FINISH
    } state_t;

    state_t          state_reg,     state_next;
    logic [63:0]     x_reg,         x_next;
    logic [63:0]     lo_reg,        lo_next;
    logic            round_reg,     round_next;
    logic [IW-1:0]   pos_reg,       pos_next;
    logic [IW-1:0]   n_reg,         n_next;
    logic [CW-1:0]   cnt_reg,       cnt_next;
    req_t            req_reg,       req_next;
    rsp_t            res_reg,       res_next;
    logic            out_valid_reg, out_valid_next;
    rsp_t            out_data_reg,  out_data_next;
    logic [VAL_W-1:0] miss_reg,     miss_next;

    logic [31:0]     mul_a;
    logic [PW-1:0]   mul_p;
    logic [63:0]     hi_sum;
    logic [63:0]     mixed;
    logic [IW-1:0]   start_slot;

    logic            ram_we;
    logic [IW-1:0]   ram_waddr;
    slot_entry_t     ram_wdata;
    logic            ram_re;
    logic [IW-1:0]   ram_raddr;
    logic [EW-1:0]   ram_rdata;
    slot_entry_t     rd_entry;

    logic            probe_free;
    logic            probe_hit;
    logic            probe_end;
    logic            load_full;

    lpht_ram #(
        .WIDTH (EW),
        .DEPTH (SLOTS)
    ) u_slots (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_entry = slot_entry_t'(ram_rdata);

    // shared 32x27 multiplier: low half then high half of x
    assign mul_a  = (state_reg == S_MUL_HI) ? x_reg[63:32] : x_reg[31:0];
    assign mul_p  = PW'(mul_a) * PW'(HASH_MUL);
    assign hi_sum = lo_reg + {mul_p[31:0], 32'd0};
    assign mixed  = (hi_sum >> HASH_SHIFT) ^ hi_sum;
    assign start_slot = x_reg[IW-1:0];

    assign probe_free = !rd_entry.used;
    assign probe_hit  = rd_entry.used && (rd_entry.key == req_reg.key);
    assign probe_end  = probe_free || probe_hit || (n_reg == LAST_SLOT);
    assign load_full  = {cnt_reg, 2'b00} >= LOAD_LIMIT;

    always_comb
    begin
        state_next     = state_reg;
        x_next         = x_reg;
        lo_next        = lo_reg;
        round_next     = round_reg;
        pos_next       = pos_reg;
        n_next         = n_reg;
        cnt_next       = cnt_reg;
        req_next       = req_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        miss_next      = miss_reg;
        ram_we         = 1'b0;
        ram_waddr      = pos_reg;
        ram_wdata      = '0;
        ram_re         = 1'b0;
        ram_raddr      = pos_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (cfg_wr_en)
        begin
            miss_next = cfg_wr_data;
        end

        unique case (state_reg)
            S_CLEAR:
            begin
                ram_we   = 1'b1;
                pos_next = pos_reg + 1'b1;
                if (pos_reg == LAST_SLOT)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    req_next   = in_data;
                    x_next     = (in_data.key >> HASH_SHIFT) ^ in_data.key;
                    round_next = 1'b0;
                    res_next   = '{found: 1'b0, value_out: miss_reg, status: STATUS_OK};
                    if ((in_data.req_type == REQ_LOOKUP)
                        && ((in_data.key == '0) || (cnt_reg == '0)))
                    begin
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        state_next = S_MUL_LO;
                    end
                end
            end
            S_MUL_LO:
            begin
                lo_next    = 64'(mul_p);
                state_next = S_MUL_HI;
            end
            S_MUL_HI:
            begin
                x_next = mixed;
                if (round_reg)
                begin
                    state_next = S_SLOT;
                end
                else
                begin
                    round_next = 1'b1;
                    state_next = S_MUL_LO;
                end
            end
            S_SLOT:
            begin
                ram_re     = 1'b1;
                ram_raddr  = start_slot;
                pos_next   = start_slot;
                n_next     = '0;
                state_next = S_PROBE;
            end
            S_PROBE:
            begin
                if (!probe_end)
                begin
                    ram_re    = 1'b1;
                    ram_raddr = pos_reg + 1'b1;
                    pos_next  = pos_reg + 1'b1;
                    n_next    = n_reg + 1'b1;
                end
                else
                begin
                    state_next = S_FINISH;
                    ram_wdata  = '{used: 1'b1, key: req_reg.key, value: req_reg.value_in};
                    if (req_reg.req_type == REQ_LOOKUP)
                    begin
                        if (probe_hit)
                        begin
                            res_next.found     = 1'b1;
                            res_next.value_out = rd_entry.value;
                        end
                    end
                    else if (probe_hit)
                    begin
                        ram_we         = 1'b1;
                        res_next.found = 1'b1;
                    end
                    else if (load_full || !probe_free)
                    begin
                        res_next.status = STATUS_FULL;
                    end
                    else
                    begin
                        ram_we   = 1'b1;
                        cnt_next = cnt_reg + 1'b1;
                    end
                end
            end
            S_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = res_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            x_reg         <= '0;
            lo_reg        <= '0;
            round_reg     <= 1'b0;
            pos_reg       <= '0;
            n_reg         <= '0;
            cnt_reg       <= '0;
            req_reg       <= '0;
            res_reg       <= '0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
            miss_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            x_reg         <= x_next;
            lo_reg        <= lo_next;
            round_reg     <= round_next;
            pos_reg       <= pos_next;
            n_reg         <= n_next;
            cnt_reg       <= cnt_next;
            req_reg       <= req_next;
            res_reg       <= res_next;
            out_valid_reg <= out_valid_next;
            out_data_reg  <= out_data_next;
            miss_reg      <= miss_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

/* rtl/lpht_checker.sv */
`include "assert_macros.svh"

module lpht_checker (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready
);

    // nothing offered or taken while in reset
    `ASSERT_ALWAYS(a_quiet_in_reset, clk, !rst_n |-> (!out_valid && !in_ready))

    // one request at a time: busy straight after an accept
    `ASSERT_ACTIVE(a_busy_after_req, clk, rst_n, (in_valid && in_ready) |=> !in_ready)

    // a result only appears out of a busy cycle
    `ASSERT_ACTIVE(a_result_from_work, clk, rst_n, $rose(out_valid) |-> !$past(in_ready))

    // a result is held until taken
    `ASSERT_ACTIVE(a_result_held, clk, rst_n, (out_valid && !out_ready) |=> out_valid)

endmodule

bind linear_probe_hash_table_unit lpht_checker u_lpht_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready)
);
